// ===== src/znsd_pkg.sv =====
package znsd_pkg;

    localparam int SAMP_W  = 16;
    localparam int QMAX    = 64;
    localparam int SMAX    = 256;
    localparam int QA_W    = 6;
    localparam int SA_W    = 8;
    localparam int QC_W    = 7;
    localparam int SC_W    = 9;
    localparam int DIVN_W  = 48;
    localparam int DIVD_W  = 32;
    localparam int DIVC_W  = 6;
    localparam int SQI_W   = 64;
    localparam int SQO_W   = 32;
    localparam int SQC_W   = 6;
    localparam int Z_W     = 22;
    localparam int DIST_W  = 16;
    localparam int DIST_MAX = 32768;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_FLAT  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_P1_RD,
        ST_P1_ACC,
        ST_P1_SQ,
        ST_CALC1,
        ST_CALC2,
        ST_CALC3,
        ST_SQRT_WAIT,
        ST_P2_RD,
        ST_P2_NUM,
        ST_P2_DIV,
        ST_P2_WAIT,
        ST_P2_SQ,
        ST_P2_ACC,
        ST_WIN_END,
        ST_FIN_DIV,
        ST_FIN_DWAIT,
        ST_FIN_SQ,
        ST_FIN_SWAIT
    } state_t;

endpackage

// ===== src/znorm_subsequence_min_distance_unit.sv =====
// Load: one sample item per cycle while idle, busy stays low; query and series go to on-chip stores.
// Search after a series last item keeps busy high; it uses one shared divider (one division
// per z-score) and one sqrt unit.
// Short series or tiny query: result with no search, from the start state. One result, valid for
// one cycle, no backpressure. Async active-low reset clears counts, flags and the sequencer.
module znorm_subsequence_min_distance_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   req_type,
    input  logic signed [znsd_pkg::SAMP_W-1:0]     sample,
    input  logic                                   last,
    output logic                                   valid,
    output logic [znsd_pkg::DIST_W-1:0]            distance,
    output logic [1:0]                             status
);

    znsd_pkg::state_t state_reg, state_next;

    logic [znsd_pkg::QC_W-1:0]      q_cnt_reg, q_cnt_next;
    logic [znsd_pkg::SC_W-1:0]      s_cnt_reg, s_cnt_next;
    logic                           q_done_reg, q_done_next;
    logic [31:0]                    best_reg, best_next;
    logic                           norm_q_reg, norm_q_next;
    logic [znsd_pkg::QC_W-1:0]      k_reg, k_next;
    logic [znsd_pkg::SC_W-1:0]      w_reg, w_next;
    logic signed [22:0]             s1_reg, s1_next;
    logic [36:0]                    s2_reg, s2_next;
    logic [31:0]                    sq_reg, sq_next;
    logic [43:0]                    s1sq_reg, s1sq_next;
    logic [43:0]                    ls2_reg, ls2_next;
    logic [43:0]                    c_reg, c_next;
    logic [znsd_pkg::SQO_W-1:0]     root_reg, root_next;
    logic signed [24:0]             num_reg, num_next;
    logic signed [22:0]             d_reg, d_next;
    logic [43:0]                    dsq_reg, dsq_next;
    logic [50:0]                    acc_reg, acc_next;
    logic [znsd_pkg::DIVN_W-1:0]    fq_reg, fq_next;
    logic                           valid_reg, valid_next;
    logic [znsd_pkg::DIST_W-1:0]    distance_reg, distance_next;
    logic [1:0]                     status_reg, status_next;

    logic signed [znsd_pkg::SAMP_W-1:0] query_mem  [znsd_pkg::QMAX];
    logic signed [znsd_pkg::SAMP_W-1:0] series_mem [znsd_pkg::SMAX];
    logic signed [znsd_pkg::Z_W-1:0]    qz_mem     [znsd_pkg::QMAX];
    logic signed [znsd_pkg::SAMP_W-1:0] q_rd_reg;
    logic signed [znsd_pkg::SAMP_W-1:0] s_rd_reg;
    logic signed [znsd_pkg::Z_W-1:0]    qz_rd_reg;

    logic                           qmem_we, smem_we, qz_we;
    logic [znsd_pkg::QA_W-1:0]      qmem_waddr;
    logic [znsd_pkg::SA_W-1:0]      s_raddr;
    logic [znsd_pkg::QC_W-1:0]      q_cnt_eff;
    logic signed [znsd_pkg::SAMP_W-1:0] v;
    logic signed [7:0]              l_s;
    logic signed [23:0]             lv;
    logic signed [31:0]             vv;
    logic signed [45:0]             s1s1;
    logic [43:0]                    ls2_w;
    logic [23:0]                    num_mag;
    logic signed [znsd_pkg::Z_W-1:0] z;
    logic [znsd_pkg::Z_W-2:0]       zmag;
    logic [21:0]                    dmag;
    logic [31:0]                    win_sum;
    logic                           last_k;
    logic                           win_more;
    logic                           fin;
    znsd_pkg::status_t              fin_stat;
    logic [znsd_pkg::DIST_W-1:0]    fin_dist;

    logic                           div_go, div_done;
    logic [znsd_pkg::DIVN_W-1:0]    div_n, div_q;
    logic [znsd_pkg::DIVD_W-1:0]    div_d;
    logic                           sq_go, sq_done;
    logic [znsd_pkg::SQI_W-1:0]     sq_in;
    logic [znsd_pkg::SQO_W-1:0]     sq_root;

    znsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    znsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sq_go),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign q_cnt_eff  = q_done_reg ? '0 : q_cnt_reg;
    assign qmem_waddr = q_cnt_eff[znsd_pkg::QA_W-1:0];
    assign s_raddr    = znsd_pkg::SA_W'(w_reg + {2'b00, k_reg});
    assign v          = norm_q_reg ? q_rd_reg : s_rd_reg;
    assign l_s        = $signed({1'b0, q_cnt_reg});
    assign lv         = l_s * v;
    assign vv         = v * v;
    assign s1s1       = s1_reg * s1_reg;
    assign ls2_w      = q_cnt_reg * s2_reg;
    assign num_mag    = num_reg[24] ? 24'(-num_reg) : num_reg[23:0];
    assign zmag       = div_q[znsd_pkg::Z_W-2:0];
    assign z          = num_reg[24] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
    assign dmag       = d_reg[22] ? 22'(-d_reg) : d_reg[21:0];
    assign win_sum    = (|acc_reg[50:40]) ? 32'hFFFF_FFFF : acc_reg[39:8];
    assign last_k     = (k_reg + 1'b1) == q_cnt_reg;
    assign win_more   = ({1'b0, w_reg} + 10'd1 + {3'b000, q_cnt_reg}) <= {1'b0, s_cnt_reg};

    assign div_n = (state_reg == znsd_pkg::ST_FIN_DIV)
                 ? {8'd0, best_reg, 8'd0}
                 : {num_mag, 24'd0} + {17'd0, root_reg[znsd_pkg::SQO_W-1:1]};
    assign div_d = (state_reg == znsd_pkg::ST_FIN_DIV)
                 ? {25'd0, q_cnt_reg} : root_reg;
    assign sq_in = (state_reg == znsd_pkg::ST_FIN_SQ)
                 ? {16'd0, fq_reg} : {c_reg, 20'd0};

    always_comb
    begin
        state_next    = state_reg;
        q_cnt_next    = q_cnt_reg;
        s_cnt_next    = s_cnt_reg;
        q_done_next   = q_done_reg;
        best_next     = best_reg;
        norm_q_next   = norm_q_reg;
        k_next        = k_reg;
        w_next        = w_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        sq_next       = sq_reg;
        s1sq_next     = s1sq_reg;
        ls2_next      = ls2_reg;
        c_next        = c_reg;
        root_next     = root_reg;
        num_next      = num_reg;
        d_next        = d_reg;
        dsq_next      = dsq_reg;
        acc_next      = acc_reg;
        fq_next       = fq_reg;
        valid_next    = 1'b0;
        distance_next = distance_reg;
        status_next   = status_reg;
        qmem_we       = 1'b0;
        smem_we       = 1'b0;
        qz_we         = 1'b0;
        div_go        = 1'b0;
        sq_go         = 1'b0;
        fin           = 1'b0;
        fin_stat      = znsd_pkg::STAT_OK;
        fin_dist      = '0;

        case (state_reg)
            znsd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!req_type)
                    begin
                        qmem_we     = q_cnt_eff < znsd_pkg::QC_W'(znsd_pkg::QMAX);
                        q_cnt_next  = q_cnt_eff + znsd_pkg::QC_W'(qmem_we);
                        q_done_next = last;
                    end
                    else
                    begin
                        smem_we    = s_cnt_reg < znsd_pkg::SC_W'(znsd_pkg::SMAX);
                        s_cnt_next = s_cnt_reg + znsd_pkg::SC_W'(smem_we);
                        if (last)
                            state_next = znsd_pkg::ST_START;
                    end
                end
            end
            znsd_pkg::ST_START:
            begin
                best_next = 32'hFFFF_FFFF;
                if ({2'b00, q_cnt_reg} > s_cnt_reg)
                begin
                    fin      = 1'b1;
                    fin_stat = znsd_pkg::STAT_SHORT;
                end
                else if (q_cnt_reg < znsd_pkg::QC_W'(2))
                begin
                    fin      = 1'b1;
                    fin_stat = znsd_pkg::STAT_FLAT;
                end
                else
                begin
                    norm_q_next = 1'b1;
                    k_next      = '0;
                    w_next      = '0;
                    s1_next     = '0;
                    s2_next     = '0;
                    state_next  = znsd_pkg::ST_P1_RD;
                end
            end
            znsd_pkg::ST_P1_RD:
                state_next = znsd_pkg::ST_P1_ACC;
            znsd_pkg::ST_P1_ACC:
            begin
                s1_next    = s1_reg + {{7{v[znsd_pkg::SAMP_W-1]}}, v};
                sq_next    = vv;
                state_next = znsd_pkg::ST_P1_SQ;
            end
            znsd_pkg::ST_P1_SQ:
            begin
                s2_next = s2_reg + {5'd0, sq_reg};
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = znsd_pkg::ST_CALC1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = znsd_pkg::ST_P1_RD;
                end
            end
            znsd_pkg::ST_CALC1:
            begin
                s1sq_next  = s1s1[43:0];
                ls2_next   = ls2_w;
                state_next = znsd_pkg::ST_CALC2;
            end
            znsd_pkg::ST_CALC2:
            begin
                c_next     = ls2_reg - s1sq_reg;
                state_next = znsd_pkg::ST_CALC3;
            end
            znsd_pkg::ST_CALC3:
            begin
                if (c_reg == '0)
                begin
                    fin      = 1'b1;
                    fin_stat = znsd_pkg::STAT_FLAT;
                end
                else
                begin
                    sq_go      = 1'b1;
                    state_next = znsd_pkg::ST_SQRT_WAIT;
                end
            end
            znsd_pkg::ST_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    root_next  = sq_root;
                    state_next = znsd_pkg::ST_P2_RD;
                end
            end
            znsd_pkg::ST_P2_RD:
                state_next = znsd_pkg::ST_P2_NUM;
            znsd_pkg::ST_P2_NUM:
            begin
                num_next   = {lv[23], lv} - {{2{s1_reg[22]}}, s1_reg};
                state_next = znsd_pkg::ST_P2_DIV;
            end
            znsd_pkg::ST_P2_DIV:
            begin
                div_go     = 1'b1;
                state_next = znsd_pkg::ST_P2_WAIT;
            end
            znsd_pkg::ST_P2_WAIT:
            begin
                if (div_done)
                begin
                    if (norm_q_reg)
                    begin
                        qz_we      = 1'b1;
                        state_next = znsd_pkg::ST_P2_ACC;
                    end
                    else
                    begin
                        d_next     = {z[znsd_pkg::Z_W-1], z}
                                   - {qz_rd_reg[znsd_pkg::Z_W-1], qz_rd_reg};
                        state_next = znsd_pkg::ST_P2_SQ;
                    end
                end
            end
            znsd_pkg::ST_P2_SQ:
            begin
                dsq_next   = dmag * dmag;
                state_next = znsd_pkg::ST_P2_ACC;
            end
            znsd_pkg::ST_P2_ACC:
            begin
                if (!norm_q_reg)
                    acc_next = acc_reg + {7'd0, dsq_reg};
                if (last_k)
                begin
                    k_next = '0;
                    if (norm_q_reg)
                    begin
                        norm_q_next = 1'b0;
                        w_next      = '0;
                        s1_next     = '0;
                        s2_next     = '0;
                        acc_next    = '0;
                        state_next  = znsd_pkg::ST_P1_RD;
                    end
                    else
                        state_next = znsd_pkg::ST_WIN_END;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = znsd_pkg::ST_P2_RD;
                end
            end
            znsd_pkg::ST_WIN_END:
            begin
                if (win_sum < best_reg)
                    best_next = win_sum;
                if (win_more)
                begin
                    w_next     = w_reg + 1'b1;
                    s1_next    = '0;
                    s2_next    = '0;
                    acc_next   = '0;
                    state_next = znsd_pkg::ST_P1_RD;
                end
                else
                    state_next = znsd_pkg::ST_FIN_DIV;
            end
            znsd_pkg::ST_FIN_DIV:
            begin
                div_go     = 1'b1;
                state_next = znsd_pkg::ST_FIN_DWAIT;
            end
            znsd_pkg::ST_FIN_DWAIT:
            begin
                if (div_done)
                begin
                    fq_next    = div_q;
                    state_next = znsd_pkg::ST_FIN_SQ;
                end
            end
            znsd_pkg::ST_FIN_SQ:
            begin
                sq_go      = 1'b1;
                state_next = znsd_pkg::ST_FIN_SWAIT;
            end
            znsd_pkg::ST_FIN_SWAIT:
            begin
                if (sq_done)
                begin
                    fin      = 1'b1;
                    fin_stat = znsd_pkg::STAT_OK;
                    fin_dist = (sq_root > znsd_pkg::SQO_W'(znsd_pkg::DIST_MAX))
                             ? znsd_pkg::DIST_W'(znsd_pkg::DIST_MAX)
                             : sq_root[znsd_pkg::DIST_W-1:0];
                end
            end
            default:
                state_next = znsd_pkg::ST_IDLE;
        endcase

        if (fin)
        begin
            valid_next    = 1'b1;
            status_next   = fin_stat;
            distance_next = fin_dist;
            s_cnt_next    = '0;
            state_next    = znsd_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= znsd_pkg::ST_IDLE;
            q_cnt_reg  <= '0;
            s_cnt_reg  <= '0;
            q_done_reg <= 1'b0;
            best_reg   <= 32'hFFFF_FFFF;
            norm_q_reg <= 1'b0;
            k_reg      <= '0;
            w_reg      <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            q_cnt_reg  <= q_cnt_next;
            s_cnt_reg  <= s_cnt_next;
            q_done_reg <= q_done_next;
            best_reg   <= best_next;
            norm_q_reg <= norm_q_next;
            k_reg      <= k_next;
            w_reg      <= w_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        sq_reg       <= sq_next;
        s1sq_reg     <= s1sq_next;
        ls2_reg      <= ls2_next;
        c_reg        <= c_next;
        root_reg     <= root_next;
        num_reg      <= num_next;
        d_reg        <= d_next;
        dsq_reg      <= dsq_next;
        acc_reg      <= acc_next;
        fq_reg       <= fq_next;
        distance_reg <= distance_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (qmem_we)
            query_mem[qmem_waddr] <= sample;
        q_rd_reg <= query_mem[k_reg[znsd_pkg::QA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
            series_mem[s_cnt_reg[znsd_pkg::SA_W-1:0]] <= sample;
        s_rd_reg <= series_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (qz_we)
            qz_mem[k_reg[znsd_pkg::QA_W-1:0]] <= z;
        qz_rd_reg <= qz_mem[k_reg[znsd_pkg::QA_W-1:0]];
    end

    assign busy     = state_reg != znsd_pkg::ST_IDLE;
    assign valid    = valid_reg;
    assign distance = distance_reg;
    assign status   = status_reg;

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> state_reg == znsd_pkg::ST_IDLE)
        else $error("result strobe while search running");

    a_series_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type && last |=> state_reg == znsd_pkg::ST_START)
        else $error("series last item did not start search");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (status_reg == znsd_pkg::STAT_OK || status_reg == znsd_pkg::STAT_SHORT
                       || status_reg == znsd_pkg::STAT_FLAT))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg != znsd_pkg::STAT_OK |-> distance_reg == '0)
        else $error("error result with nonzero distance");

    a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> distance_reg <= znsd_pkg::DIST_W'(znsd_pkg::DIST_MAX))
        else $error("distance above saturation limit");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= znsd_pkg::QC_W'(znsd_pkg::QMAX)
        && s_cnt_reg <= znsd_pkg::SC_W'(znsd_pkg::SMAX))
        else $error("sample count overflow");

endmodule

// ===== src/znsd_div.sv =====
module znsd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [znsd_pkg::DIVN_W-1:0]       dividend,
    input  logic [znsd_pkg::DIVD_W-1:0]       divisor,
    output logic                              done,
    output logic [znsd_pkg::DIVN_W-1:0]       quotient
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [znsd_pkg::DIVC_W-1:0]     cnt_reg, cnt_next;
    logic [znsd_pkg::DIVN_W-1:0]     quo_reg, quo_next;
    logic [znsd_pkg::DIVD_W-1:0]     rem_reg, rem_next;
    logic [znsd_pkg::DIVD_W-1:0]     dvs_reg, dvs_next;
    logic [znsd_pkg::DIVD_W:0]       sh;
    logic                            ge;

    assign sh = {rem_reg, quo_reg[znsd_pkg::DIVN_W-1]};
    assign ge = sh >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = znsd_pkg::DIVC_W'(znsd_pkg::DIVN_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? znsd_pkg::DIVD_W'(sh - {1'b0, dvs_reg})
                          : sh[znsd_pkg::DIVD_W-1:0];
            quo_next = {quo_reg[znsd_pkg::DIVN_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == znsd_pkg::DIVC_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/znsd_sqrt.sv =====
module znsd_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [znsd_pkg::SQI_W-1:0]        radicand,
    output logic                              done,
    output logic [znsd_pkg::SQO_W-1:0]        root
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [znsd_pkg::SQC_W-1:0]      cnt_reg, cnt_next;
    logic [znsd_pkg::SQI_W-1:0]      rad_reg, rad_next;
    logic [znsd_pkg::SQO_W+1:0]      rem_reg, rem_next;
    logic [znsd_pkg::SQO_W-1:0]      root_reg, root_next;
    logic [znsd_pkg::SQO_W+3:0]      r4;
    logic [znsd_pkg::SQO_W+3:0]      trial;
    logic                            ge;

    assign r4    = {rem_reg, rad_reg[znsd_pkg::SQI_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = r4 >= trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (go)
        begin
            run_next  = 1'b1;
            cnt_next  = znsd_pkg::SQC_W'(znsd_pkg::SQO_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? (znsd_pkg::SQO_W+2)'(r4 - trial) : r4[znsd_pkg::SQO_W+1:0];
            root_next = {root_reg[znsd_pkg::SQO_W-2:0], ge};
            rad_next  = {rad_reg[znsd_pkg::SQI_W-3:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == znsd_pkg::SQC_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== tb/znorm_subsequence_min_distance_unit_tb.sv =====
`timescale 1ns / 100ps

class distance_scoreboard;
    typedef struct {
        logic [15:0] dst;
        logic [1:0]  stat;
    } match_t;

    match_t      pending[$];
    int          errors;
    int          results_seen;
    longint      query_mem[64];
    longint      series_mem[256];
    int          qcnt;
    int          scnt;
    bit          qdone;
    longint      qz[64];
    longint      wz[64];

    function new();
        errors = 0;
        results_seen = 0;
        qcnt = 0;
        scnt = 0;
        qdone = 0;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // z-scores of a query or series window into qz or wz; 0 when flat
    function automatic bit zscore(bit ser, int base, int len);
        longint      s1;
        longint      v;
        longint      num;
        logic [63:0] s2;
        logic [63:0] c;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] q;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < len; i++)
        begin
            v = ser ? series_mem[base + i] : query_mem[i];
            u = v;
            s1 += v;
            s2 += u * u;
        end
        c = 64'(len) * s2 - 64'(s1) * 64'(s1);
        if (c == 0)
            return 0;
        r = int_root(c << 20);
        if (r == 0)
            return 0;
        for (int i = 0; i < len; i++)
        begin
            v = ser ? series_mem[base + i] : query_mem[i];
            num = longint'(len) * v - s1;
            u = (num < 0) ? 64'(-num) : 64'(num);
            q = ((u << 24) + (r >> 1)) / r;
            if (ser)
                wz[i] = (num < 0) ? -longint'(q) : longint'(q);
            else
                qz[i] = (num < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic match_t search();
        match_t      m;
        logic [63:0] sum;
        logic [63:0] d;
        logic [63:0] rt_val;
        logic [31:0] best;
        longint      diff;
        m.dst = 0;
        best = 32'hFFFF_FFFF;
        if (scnt < qcnt)
        begin
            m.stat = znsd_pkg::STAT_SHORT;
            return m;
        end
        if (qcnt < 2 || !zscore(0, 0, qcnt))
        begin
            m.stat = znsd_pkg::STAT_FLAT;
            return m;
        end
        for (int w = 0; w + qcnt <= scnt; w++)
        begin
            if (!zscore(1, w, qcnt))
            begin
                m.stat = znsd_pkg::STAT_FLAT;
                return m;
            end
            sum = 0;
            for (int k = 0; k < qcnt; k++)
            begin
                diff = wz[k] - qz[k];
                d = (diff < 0) ? 64'(-diff) : 64'(diff);
                sum += d * d;
            end
            sum = sum >> 8;
            if (sum > 64'hFFFF_FFFF)
                sum = 64'hFFFF_FFFF;
            if (sum < best)
                best = sum[31:0];
        end
        rt_val = int_root((64'(best) << 8) / qcnt);
        if (rt_val > znsd_pkg::DIST_MAX)
            rt_val = znsd_pkg::DIST_MAX;
        m.dst = rt_val[15:0];
        m.stat = znsd_pkg::STAT_OK;
        return m;
    endfunction

    function void note_item(bit rt, logic signed [15:0] s, bit lst);
        if (!rt)
        begin
            if (qdone)
            begin
                qcnt = 0;
                qdone = 0;
            end
            if (qcnt < 64)
            begin
                query_mem[qcnt] = s;
                qcnt++;
            end
            if (lst)
                qdone = 1;
            return;
        end
        if (scnt < 256)
        begin
            series_mem[scnt] = s;
            scnt++;
        end
        if (lst)
        begin
            pending.insert(pending.size(), search());
            scnt = 0;
        end
    endfunction

    function void check_result(logic [15:0] dst_act, logic [1:0] stat);
        match_t m;
        results_seen++;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result distance %0d status %0d", $time, dst_act, stat);
            errors++;
            return;
        end
        m = pending.pop_front();
        if (dst_act !== m.dst)
        begin
            $display("%0t: distance expected %0d actual %0d", $time, m.dst, dst_act);
            errors++;
        end
        if (stat !== m.stat)
        begin
            $display("%0t: status expected %0d actual %0d", $time, m.stat, stat);
            errors++;
        end
    endfunction
endclass

module znorm_subsequence_min_distance_unit_tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               req_type;
    logic signed [15:0] sample;
    logic               last;
    logic               valid;
    logic [15:0]        distance;
    logic [1:0]         status;

    distance_scoreboard sb;
    int                 sent;
    bit                 calm;

    znorm_subsequence_min_distance_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .sample   (sample),
        .last     (last),
        .valid    (valid),
        .distance (distance),
        .status   (status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_result(distance, status);
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send(bit rt, logic signed [15:0] s, bit lst);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        sample <= s;
        last <= lst;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(rt, s, lst);
        sent++;
    endtask

    function automatic logic signed [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40) - 20);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    task automatic send_seq(bit rt, int len, int mode, bit with_last);
        logic signed [15:0] k;
        k = rand_sample(mode);
        for (int i = 0; i < len; i++)
            send(rt, (mode == 4) ? k : rand_sample(mode), with_last && (i == len - 1));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int qlen;
        int n;
        int mode;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = 1'b0;
        sample = '0;
        last = 1'b0;
        sent = 0;
        calm = 0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // series with no query at all
        send_seq(1, 3, 0, 1);
        // extreme query, then a short series
        send(0, 16'sh8000, 0);
        send(0, 16'sh7FFF, 0);
        send(0, 16'sh0000, 0);
        send(0, -16'sd1, 1);
        send_seq(1, 2, 0, 1);
        send(1, 16'sh7FFF, 0);
        send(1, 16'sh8000, 0);
        send_seq(1, 4, 0, 1);
        // new query still open when the series ends
        send_seq(0, 3, 3, 0);
        send_seq(1, 5, 3, 1);
        send_seq(0, 1, 3, 1);
        send_seq(1, 6, 2, 1);
        // flat window
        send_seq(0, 3, 1, 1);
        send(1, 16'sd5, 0);
        send(1, 16'sd5, 0);
        send(1, 16'sd5, 0);
        send(1, 16'sd1, 0);
        send(1, 16'sd2, 1);
        // flat query, one-sample query
        send_seq(0, 3, 4, 1);
        send_seq(1, 4, 0, 1);
        send_seq(0, 1, 0, 1);
        send_seq(1, 3, 0, 1);
        drain();
        // both stores overflowing
        send_seq(0, 66, 0, 1);
        send_seq(1, 70, 0, 1);
        send_seq(0, 2, 0, 1);
        send_seq(1, 260, 3, 1);
        drain();

        while (sent < 1200)
        begin
            calm = (sent > 1050);
            if ($urandom_range(0, 9) < 8)
            begin
                qlen = $urandom_range(0, 9) == 0 ? $urandom_range(1, 16) : $urandom_range(2, 6);
                send_seq(0, qlen, $urandom_range(0, 3), 1);
                repeat ($urandom_range(1, 3))
                begin
                    n = $urandom_range(0, 7) == 0 ? $urandom_range(1, qlen) :
                        qlen + $urandom_range(0, 10);
                    mode = $urandom_range(0, 11) == 0 ? 4 : $urandom_range(0, 3);
                    send_seq(1, n, mode, 1);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send(1'($urandom_range(0, 1)), rand_sample($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 15) == 0)
                drain();
        end
        send_seq(1, 1, 0, 1);

        start <= 1'b0;
        n = 0;
        while (sb.pending.size() != 0 && n < 3000000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
